/* design/sbc_pkg.sv */
// Package of the sector buffer cache tag engine.
// Holds widths, codes and the structures shared by the cells and the top level.
// Depends on nothing.
package sbc_pkg;

	localparam int unsigned MAX_SLOTS   = 64;
	localparam int unsigned DEF_SLOTS   = 8;
	localparam int unsigned IDX_W       = 6;
	localparam int unsigned SECT_W      = 48;
	localparam int unsigned SPB_W       = 17;
	localparam int unsigned STAMP_W     = 64;
	localparam int unsigned CNT_W       = 4;
	localparam int unsigned MAX_WB      = 8;
	localparam int unsigned SLOT_OUT_W  = 3;
	localparam int unsigned CFG_IDX_W   = 1;

	localparam logic [SPB_W-1:0] SPB_RESET = 17'd8;

	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_FLUSH = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_RANGE   = 2'd1;
	localparam logic [1:0] STATUS_NODRIVE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SPB = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOL = 1'd1;

	typedef struct packed {
		logic               v;
		logic [CNT_W-1:0]   cnt;
		logic               hit;
		logic [IDX_W-1:0]   hit_idx;
		logic               free;
		logic [IDX_W-1:0]   free_idx;
		logic               min_set;
		logic [STAMP_W-1:0] min_stamp;
		logic [IDX_W-1:0]   min_idx;
		logic               min_dirty;
		logic [SECT_W-1:0]  min_sector;
	} scan_rec_t;

	typedef struct packed {
		logic              flush;
		logic [SECT_W-1:0] sector;
		logic [SPB_W-1:0]  span;
	} bcast_t;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   idx;
		logic               fill;
		logic [SECT_W-1:0]  first;
		logic [STAMP_W-1:0] stamp;
		logic               write;
	} upd_t;

	typedef struct packed {
		logic              req;
		logic [IDX_W-1:0]  idx;
		logic [SECT_W-1:0] sector;
	} emit_t;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot_index;
		logic                  hit;
		logic                  writeback_valid;
		logic [SECT_W-1:0]     writeback_sector;
		logic                  fill_valid;
		logic [SECT_W-1:0]     fill_sector;
		logic [1:0]            status;
		logic                  last;
	} result_t;

endpackage

/* design/sbc_if.sv */
// Handshake channels of the sector buffer cache tag engine.
// Depends on sbc_pkg for field widths.
interface sbc_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [sbc_pkg::SECT_W-1:0] sector_address;

	modport source (output valid, output mode, output sector_address, input ready);
	modport sink (input valid, input mode, input sector_address, output ready);
endinterface

interface sbc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [sbc_pkg::SLOT_OUT_W-1:0] slot_index;
	logic                          hit;
	logic                          writeback_valid;
	logic [sbc_pkg::SECT_W-1:0]     writeback_sector;
	logic                          fill_valid;
	logic [sbc_pkg::SECT_W-1:0]     fill_sector;
	logic [1:0]                    status;
	logic                          last;

	modport source (output valid, output slot_index, output hit, output writeback_valid,
		output writeback_sector, output fill_valid, output fill_sector, output status,
		output last, input ready);
	modport sink (input valid, input slot_index, input hit, input writeback_valid,
		input writeback_sector, input fill_valid, input fill_sector, input status,
		input last, output ready);
endinterface

/* design/sector_buffer_cache_lru.sv */
// Top level of the sector buffer cache tag engine: controller, divider and slot chain.
// Depends on sbc_pkg, sbc_if, sbc_cell and sbc_div.
//
//   channel  role    beat carries
//   req      sink    mode, sector_address
//   rsp      source  slot_index, hit, writeback/fill fields, status, last
//   cfg      write   cfg_we, cfg_index, cfg_data
//
// An access is accepted only in the idle state, so a new access waits until the last one is
// done. The 48-step remainder divider runs alongside the slot scan, which moves one cell a
// cycle except while a flush write-back beat waits on rsp; a flush skips the divider.
// Rejected and no-drive beats go straight to the final beat, and an undefined mode is dropped.
// Reset clears all marks, stamps and the use counter at once. One output register
// decouples rsp from the next req beat.
module sector_buffer_cache_lru #(
	parameter int unsigned NUM_SLOTS = sbc_pkg::DEF_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbc_pkg::SECT_W-1:0]    cfg_data,
	sbc_req_if.sink                       req,
	sbc_rsp_if.source                     rsp
);
	import sbc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DEC  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [SPB_W-1:0]   spb_q;
	logic [SECT_W-1:0]  vol_q;
	logic [STAMP_W-1:0] use_cnt_q;
	logic [1:0]         mode_q;
	logic [SECT_W-1:0]  sector_q;
	logic               start_q;
	scan_rec_t          res_q;
	logic               pend_v_q;
	result_t            pend_q;
	logic               out_v_q;
	result_t            out_q;

	logic [SPB_W-1:0]   span;
	logic               accept;
	logic               out_free;
	logic               adv;
	logic               emit_ok;
	logic               div_start;
	logic               scan_start;
	logic               out_load;
	logic [SPB_W-1:0]   div_rem;
	logic               div_done;
	bcast_t             bc;
	upd_t               upd;
	scan_rec_t          inj;
	scan_rec_t          rec [NUM_SLOTS];
	emit_t              em [NUM_SLOTS];
	emit_t              em_all;
	result_t            dec_res;
	result_t            emit_res;
	result_t            rej_res;
	result_t            fin_res;
	logic [IDX_W-1:0]   dec_slot;

	assign span     = (spb_q == '0) ? SPB_W'(1) : spb_q;
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !out_v_q || rsp.ready;

	assign bc.flush  = (mode_q == MODE_FLUSH);
	assign bc.sector = sector_q;
	assign bc.span   = span;

	always_comb begin
		inj   = '0;
		inj.v = start_q;
	end

	assign div_start = accept && (vol_q != '0) && (req.mode != MODE_FLUSH) &&
		(req.mode != MODE_NONE) && (req.sector_address < vol_q);

	assign scan_start = accept && (vol_q != '0) && (req.mode != MODE_NONE) &&
		((req.mode == MODE_FLUSH) || (req.sector_address < vol_q));

	sbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.sector_address),
		.divisor  (span),
		.rem      (div_rem),
		.done     (div_done)
	);

	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
		sbc_cell #(.IDX(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.bc     (bc),
			.upd    (upd),
			.rin    ((k == 0) ? inj : rec[(k == 0) ? 0 : k - 1]),
			.rout   (rec[k]),
			.em     (em[k])
		);
	end

	always_comb begin
		em_all = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (em[k].req) begin
				em_all.req    = 1'b1;
				em_all.idx    = em_all.idx | em[k].idx;
				em_all.sector = em_all.sector | em[k].sector;
			end
		end
	end

	assign emit_ok = !pend_v_q || out_free;
	assign adv     = !(em_all.req && !emit_ok);

	assign out_load = ((state_q == ST_SCAN) && em_all.req && emit_ok && pend_v_q) ||
		((state_q == ST_FIN) && out_free);

	always_comb begin
		emit_res                  = '0;
		emit_res.slot_index       = em_all.idx[SLOT_OUT_W-1:0];
		emit_res.writeback_valid  = 1'b1;
		emit_res.writeback_sector = em_all.sector;
		emit_res.status           = STATUS_OK;
	end

	always_comb begin
		rej_res        = '0;
		rej_res.status = (vol_q == '0) ? STATUS_NODRIVE : STATUS_RANGE;
		if (pend_v_q) begin
			fin_res = pend_q;
		end else begin
			fin_res        = '0;
			fin_res.status = STATUS_OK;
		end
		fin_res.last = 1'b1;
	end

	always_comb begin
		dec_slot = res_q.hit ? res_q.hit_idx : (res_q.free ? res_q.free_idx : res_q.min_idx);
		dec_res                 = '0;
		dec_res.slot_index      = dec_slot[SLOT_OUT_W-1:0];
		dec_res.hit             = res_q.hit;
		dec_res.writeback_valid = !res_q.hit && !res_q.free && res_q.min_dirty;
		if (!res_q.hit && !res_q.free && res_q.min_dirty) begin
			dec_res.writeback_sector = res_q.min_sector;
		end
		dec_res.fill_valid = !res_q.hit;
		if (!res_q.hit) begin
			dec_res.fill_sector = SECT_W'(sector_q - SECT_W'(div_rem));
		end
		dec_res.status = STATUS_OK;
		dec_res.last   = 1'b0;

		upd       = '0;
		upd.we    = (state_q == ST_DEC) && div_done;
		upd.idx   = dec_slot;
		upd.fill  = !res_q.hit;
		upd.first = dec_res.fill_sector;
		upd.stamp = use_cnt_q;
		upd.write = (mode_q == MODE_WRITE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb_q <= SPB_RESET;
			vol_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPB: spb_q <= cfg_data[SPB_W-1:0];
				REG_VOL: vol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= req.mode;
			sector_q <= req.sector_address;
		end
		if ((state_q == ST_SCAN) && rec[NUM_SLOTS-1].v) begin
			res_q <= rec[NUM_SLOTS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= 1'b0;
			use_cnt_q <= '0;
			pend_v_q  <= 1'b0;
			pend_q    <= '0;
			out_v_q   <= 1'b0;
			out_q     <= '0;
		end else begin
			start_q <= scan_start;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.mode != MODE_NONE)) begin
						if (scan_start) begin
							state_q <= ST_SCAN;
						end else begin
							pend_v_q <= 1'b1;
							pend_q   <= rej_res;
							state_q  <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (em_all.req && emit_ok) begin
						if (pend_v_q) begin
							out_q <= pend_q;
						end
						pend_v_q <= 1'b1;
						pend_q   <= emit_res;
					end
					if (rec[NUM_SLOTS-1].v) begin
						state_q <= bc.flush ? ST_FIN : ST_DEC;
					end
				end
				ST_DEC: begin
					if (div_done) begin
						pend_v_q  <= 1'b1;
						pend_q    <= dec_res;
						use_cnt_q <= STAMP_W'(use_cnt_q + STAMP_W'(1));
						state_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_q    <= fin_res;
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid            = out_v_q;
	assign rsp.slot_index       = out_q.slot_index;
	assign rsp.hit              = out_q.hit;
	assign rsp.writeback_valid  = out_q.writeback_valid;
	assign rsp.writeback_sector = out_q.writeback_sector;
	assign rsp.fill_valid       = out_q.fill_valid;
	assign rsp.fill_sector      = out_q.fill_sector;
	assign rsp.status           = out_q.status;
	assign rsp.last             = out_q.last;

endmodule

/* design/sbc_cell.sv */
// One cache slot: its tag, marks and use stamp, and one step of the scan chain.
// Depends on sbc_pkg.
module sbc_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  sbc_pkg::bcast_t     bc,
	input  sbc_pkg::upd_t       upd,
	input  sbc_pkg::scan_rec_t  rin,
	output sbc_pkg::scan_rec_t  rout,
	output sbc_pkg::emit_t      em
);
	import sbc_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic               valid_q;
	logic               dirty_q;
	logic [SECT_W-1:0]  first_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               hit_here;
	logic               emit_req;
	logic               sel;
	scan_rec_t          next;
	scan_rec_t          rec_q;

	assign sel = upd.we && (upd.idx == MY_IDX);
	assign hit_here = valid_q && (bc.sector >= first_q) &&
		({1'b0, bc.sector} < ({1'b0, first_q} + (SECT_W + 1)'(bc.span)));
	assign emit_req = rin.v && bc.flush && valid_q && dirty_q && (rin.cnt < CNT_W'(MAX_WB));

	always_comb begin
		next = rin;
		if (rin.v && !bc.flush) begin
			if (!rin.hit && hit_here) begin
				next.hit     = 1'b1;
				next.hit_idx = MY_IDX;
			end
			if (!rin.free && !valid_q) begin
				next.free     = 1'b1;
				next.free_idx = MY_IDX;
			end
			if (!rin.min_set || (stamp_q < rin.min_stamp)) begin
				next.min_set    = 1'b1;
				next.min_stamp  = stamp_q;
				next.min_idx    = MY_IDX;
				next.min_dirty  = dirty_q;
				next.min_sector = first_q;
			end
		end
		if (emit_req) begin
			next.cnt = CNT_W'(rin.cnt + CNT_W'(1));
		end
	end

	assign em.req    = emit_req;
	assign em.idx    = MY_IDX;
	assign em.sector = first_q;
	assign rout      = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (adv) begin
			rec_q <= next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
			stamp_q <= '0;
		end else if (sel) begin
			valid_q <= 1'b1;
			dirty_q <= upd.write | (dirty_q & ~upd.fill);
			stamp_q <= upd.stamp;
		end else if (adv && emit_req) begin
			dirty_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && upd.fill) begin
			first_q <= upd.first;
		end
	end

endmodule

/* design/sbc_div.sv */
// Restoring divider that gives the remainder of a sector number by the slot size,
// one quotient bit a cycle. Depends on sbc_pkg.
module sbc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sbc_pkg::SECT_W-1:0] dividend,
	input  logic [sbc_pkg::SPB_W-1:0]  divisor,
	output logic [sbc_pkg::SPB_W-1:0]  rem,
	output logic                       done
);
	import sbc_pkg::*;

	localparam int unsigned STEP_W = $clog2(SECT_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [SECT_W-1:0] dvd_q;
	logic [SPB_W-1:0]  div_q;
	logic [SPB_W-1:0]  rem_q;
	logic [SPB_W:0]    trial;

	assign trial = {rem_q, dvd_q[SECT_W-1]};
	assign rem   = rem_q;
	assign done  = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(SECT_W);
		end else if (busy_q) begin
			step_q <= STEP_W'(step_q - STEP_W'(1));
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SECT_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= SPB_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[SPB_W-1:0];
			end
		end
	end

endmodule

/* sim/tb_sector_buffer_cache_lru.sv */
// Testbench of the sector buffer cache tag engine: drives read, write, flush and undefined-mode beats,
// predicts the slot, write-back and fill of each one, and checks every response beat.
// Depends on sbc_pkg, sbc_if and sector_buffer_cache_lru.
module tb_sector_buffer_cache_lru;
	timeunit 1ns;
	timeprecision 1ps;
	import sbc_pkg::*;

	localparam int SLOTS = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [SECT_W-1:0] SECT_MAX = {SECT_W{1'b1}};

	typedef struct packed {
		logic [1:0]        mode;
		logic [SECT_W-1:0] sector;
	} access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SPB;
	logic [SECT_W-1:0] cfg_data = '0;

	sbc_req_if req_ch();
	sbc_rsp_if rsp_ch();

	sector_buffer_cache_lru #(.NUM_SLOTS(SLOTS)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req_ch), .rsp(rsp_ch)
	);

	// Shadow of the cache tags and registers.
	logic              shadow_valid [SLOTS];
	logic              shadow_dirty [SLOTS];
	logic [63:0]       shadow_first [SLOTS];
	logic [63:0]       shadow_stamp [SLOTS];
	logic [63:0]       use_count;
	logic [SPB_W-1:0]  cur_spb;
	logic [SECT_W-1:0] cur_volume;

	access_t pending_q[$];
	result_t expected_q[$];
	int  error_count = 0;
	int  cycle_count = 0;
	int  send_gap = 0;
	int  sink_hold = 0;
	int  long_stall = 0;
	bit  idling_on = 1'b1;
	bit  req_taken = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, field,
			got, want);
		error_count++;
	endtask

	function automatic void predict_cache(logic [1:0] mode, logic [SECT_W-1:0] sector);
		result_t r;
		logic [63:0] span;
		logic [63:0] best_stamp;
		int slot;
		int n;
		r = '0;
		span = (cur_spb == '0) ? 64'd1 : 64'(cur_spb);
		slot = -1;
		n = 0;
		if (mode == MODE_NONE) return;
		if (cur_volume == '0) begin
			r.status = STATUS_NODRIVE;
			r.last = 1'b1;
			expected_q.push_back(r);
			return;
		end
		if (mode == MODE_FLUSH) begin
			for (int i = 0; i < SLOTS && n < MAX_WB; i++) begin
				if (shadow_valid[i] && shadow_dirty[i]) begin
					r = '0;
					r.slot_index = SLOT_OUT_W'(i);
					r.writeback_valid = 1'b1;
					r.writeback_sector = shadow_first[i][SECT_W-1:0];
					shadow_dirty[i] = 1'b0;
					expected_q.push_back(r);
					n++;
				end
			end
			if (n == 0) begin
				r = '0;
				r.last = 1'b1;
				expected_q.push_back(r);
			end else begin
				expected_q[$].last = 1'b1;
			end
			return;
		end
		if (sector >= cur_volume) begin
			r.status = STATUS_RANGE;
			r.last = 1'b1;
			expected_q.push_back(r);
			return;
		end
		for (int i = 0; i < SLOTS && slot < 0; i++)
			if (shadow_valid[i] && 64'(sector) >= shadow_first[i] &&
					64'(sector) < shadow_first[i] + span)
				slot = i;
		r.hit = (slot >= 0);
		if (slot < 0) begin
			for (int i = 0; i < SLOTS && slot < 0; i++)
				if (!shadow_valid[i]) slot = i;
			if (slot < 0) begin
				slot = 0;
				best_stamp = '1;
				for (int i = 0; i < SLOTS; i++)
					if (shadow_stamp[i] < best_stamp) begin
						best_stamp = shadow_stamp[i];
						slot = i;
					end
			end
			if (shadow_valid[slot] && shadow_dirty[slot]) begin
				r.writeback_valid = 1'b1;
				r.writeback_sector = shadow_first[slot][SECT_W-1:0];
			end
			r.fill_valid = 1'b1;
			r.fill_sector = SECT_W'((64'(sector) / span) * span);
			shadow_valid[slot] = 1'b1;
			shadow_dirty[slot] = 1'b0;
			shadow_first[slot] = 64'(r.fill_sector);
		end
		shadow_stamp[slot] = use_count;
		use_count++;
		if (mode == MODE_WRITE) shadow_dirty[slot] = 1'b1;
		r.slot_index = SLOT_OUT_W'(slot);
		r.last = 1'b1;
		expected_q.push_back(r);
	endfunction

	// Request side: handshake seen at the rising edge, next beat set up at the falling edge.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else if (req_ch.valid && req_ch.ready) begin
			predict_cache(req_ch.mode, req_ch.sector_address);
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		access_t a;
		if (!arst_n || (req_ch.valid && !req_taken)) begin
		end else if (send_gap > 0) begin
			send_gap--;
			req_ch.valid <= 1'b0;
			req_taken = 1'b0;
		end else if (pending_q.size() != 0) begin
			a = pending_q.pop_front();
			req_ch.valid <= 1'b1;
			req_ch.mode <= a.mode;
			req_ch.sector_address <= a.sector;
			req_taken = 1'b0;
			if (idling_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 8);
		end else begin
			req_ch.valid <= 1'b0;
			req_taken = 1'b0;
		end
	end

	// Response side.
	always @(negedge clk) begin
		if (long_stall > 0) begin
			long_stall--;
			rsp_ch.ready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold--;
			rsp_ch.ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			sink_hold = $urandom_range(0, 7);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected beat, last", 64'(rsp_ch.last), 64'd0);
			end else begin
				want = expected_q.pop_front();
				if (rsp_ch.slot_index != want.slot_index)
					report_mismatch("slot_index", 64'(rsp_ch.slot_index),
						64'(want.slot_index));
				if (rsp_ch.hit != want.hit)
					report_mismatch("hit", 64'(rsp_ch.hit), 64'(want.hit));
				if (rsp_ch.writeback_valid != want.writeback_valid)
					report_mismatch("writeback_valid", 64'(rsp_ch.writeback_valid),
						64'(want.writeback_valid));
				if (rsp_ch.writeback_sector != want.writeback_sector)
					report_mismatch("writeback_sector", 64'(rsp_ch.writeback_sector),
						64'(want.writeback_sector));
				if (rsp_ch.fill_valid != want.fill_valid)
					report_mismatch("fill_valid", 64'(rsp_ch.fill_valid),
						64'(want.fill_valid));
				if (rsp_ch.fill_sector != want.fill_sector)
					report_mismatch("fill_sector", 64'(rsp_ch.fill_sector),
						64'(want.fill_sector));
				if (rsp_ch.status != want.status)
					report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
				if (rsp_ch.last != want.last)
					report_mismatch("last", 64'(rsp_ch.last), 64'(want.last));
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [SECT_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		if (index == REG_SPB) cur_spb = value[SPB_W-1:0];
		else cur_volume = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		wait (pending_q.size() == 0 && !req_ch.valid && expected_q.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic queue_access(logic [1:0] mode, logic [SECT_W-1:0] sector);
		access_t a;
		a.mode = mode;
		a.sector = sector;
		pending_q.push_back(a);
	endtask

	task automatic queue_random(int count);
		logic [SECT_W-1:0] region [4];
		logic [SECT_W-1:0] sector;
		logic [1:0] mode;
		int pick;
		for (int i = 0; i < 4; i++)
			region[i] = SECT_W'({$urandom, $urandom}) % cur_volume;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) mode = MODE_READ;
			else if (pick < 85) mode = MODE_WRITE;
			else if (pick < 95) mode = MODE_FLUSH;
			else mode = MODE_NONE;
			pick = $urandom_range(0, 9);
			if (pick < 7)
				sector = region[$urandom_range(0, 3)] +
					SECT_W'($urandom_range(0, 3 * (cur_spb + 1)));
			else if (pick < 9)
				sector = SECT_W'({$urandom, $urandom});
			else
				sector = cur_volume - SECT_W'($urandom_range(0, 1));
			queue_access(mode, sector);
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_READ;
		req_ch.sector_address = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_dirty[i] = 1'b0;
			shadow_first[i] = '0;
			shadow_stamp[i] = '0;
		end
		use_count = '0;
		cur_spb = SPB_RESET;
		cur_volume = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With no drive attached every beat is turned away.
		queue_access(MODE_READ, 48'd5);
		queue_access(MODE_WRITE, SECT_MAX);
		queue_access(MODE_FLUSH, '0);
		queue_access(MODE_NONE, 48'd1);
		drain();
		write_reg(REG_VOL, 48'd1000);
		write_reg(REG_SPB, 48'd8);
		queue_access(MODE_READ, '0);
		queue_access(MODE_WRITE, 48'd7);
		queue_access(MODE_READ, 48'd8);
		queue_access(MODE_READ, 48'd999);
		queue_access(MODE_READ, 48'd1000);
		queue_access(MODE_WRITE, SECT_MAX);
		for (int i = 1; i <= 6; i++) queue_access(MODE_WRITE, 48'(i * 100));
		queue_access(MODE_READ, 48'd8);
		queue_access(MODE_FLUSH, SECT_MAX);
		queue_access(MODE_FLUSH, '0);
		queue_access(MODE_NONE, SECT_MAX);
		queue_access(MODE_WRITE, '0);
		queue_random(30);
		drain();

		// Slot size of zero counts as one; the receiver stalls long enough to back up req.
		write_reg(REG_SPB, 48'd0);
		write_reg(REG_VOL, 48'd50);
		long_stall = 400;
		queue_random(25);
		drain();

		write_reg(REG_SPB, 48'd65536);
		write_reg(REG_VOL, SECT_MAX);
		queue_random(30);
		drain();

		idling_on = 1'b0;
		write_reg(REG_SPB, 48'd3);
		queue_random(25);
		drain();

		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

/* sector_buffer_cache_lru.f */
design/sbc_pkg.sv
design/sbc_if.sv
design/sbc_cell.sv
design/sbc_div.sv
design/sector_buffer_cache_lru.sv
sim/tb_sector_buffer_cache_lru.sv
